// ----- hw/rtl/btm_pkg.sv -----
// Shared constants and types for the bus target memory command engine.
package btm_pkg;

   // Default memory size in bytes.
   localparam int MEM_BYTES_DEFAULT = 16384;

   // Header command codes.
   localparam logic [7:0] CMD_STORE = 8'hC0;
   localparam logic [7:0] CMD_LOAD  = 8'hC1;

   // Transfer phases, also reported on the response.
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_STORE  = 2'd1;
   localparam logic [1:0] PH_LOAD   = 2'd2;

   // Header byte positions.
   localparam logic [1:0] HDR_CMD     = 2'd0;
   localparam logic [1:0] HDR_ADDR_HI = 2'd1;
   localparam logic [1:0] HDR_ADDR_LO = 2'd2;
   localparam logic [1:0] HDR_LEN     = 2'd3;

   // Response status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_WLEN       = 3'd1;
   localparam logic [2:0] ST_RLEN       = 3'd2;
   localparam logic [2:0] ST_BADCMD     = 3'd3;
   localparam logic [2:0] ST_NOTREADY   = 3'd4;
   localparam logic [2:0] ST_UNEXPECTED = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CFG_LINK_READY    = 2'd0;
   localparam logic [1:0] CFG_MAX_WRITE_LEN = 2'd1;
   localparam logic [1:0] CFG_MAX_READ_LEN  = 2'd2;

   // Response fields carried alongside an outstanding memory read.
   typedef struct packed {
      logic       is_load;
      logic       last;
      logic [2:0] status;
      logic [1:0] phase;
   } rsp_ctl_type;

endpackage

// ----- hw/rtl/bus_target_memory_command_engine.sv -----
// Pipeline: a response passes the read stage and then the output register after acceptance.
// Throughput: one request per cycle unless the output stalls or the clearing pass runs; state
// updates at acceptance, and the RAM write port serves STORE writes, the read port LOAD reads.
// Reset: all control state and limits clear; then a clearing pass writes zero to every
// byte, during which req_tready stays low (CSR writes still taken).
module bus_target_memory_command_engine #(
   parameter int MEM_BYTES = btm_pkg::MEM_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] bus_byte
   input  logic        req_tuser,   // [0] func (1 = controller reads)
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] read_data, [10:8] status, [12:11] phase
   output logic        rsp_tuser,   // [0] read_valid
   output logic        rsp_tlast,   // read_last
   // Configuration write port.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   import btm_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);
   localparam int AC = AW + 1;
   localparam logic [AC-1:0] MEM_BOUND = AC'(MEM_BYTES);
   localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);

   // Reduces a 16-bit address modulo the memory size by binary compare and subtract.
   function automatic logic [AW-1:0] addr_mod(input logic [15:0] raw);
      logic [23:0] rem;
      rem = {8'd0, raw};
      for (int k = 7; k >= 0; k--) begin
         if (rem >= (24'(MEM_BYTES) << k)) begin
            rem = rem - (24'(MEM_BYTES) << k);
         end
      end
      return rem[AW-1:0];
   endfunction

   // Configuration registers.
   logic       link_ready_ff;
   logic [7:0] max_wr_ff;
   logic [7:0] max_rd_ff;

   // Transfer state.
   logic [1:0]    phase_ff, phase_in;
   logic [1:0]    hdr_idx_ff, hdr_idx_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    addr_hi_ff, addr_hi_in;
   logic [AC-1:0] addr_ff, addr_in;
   logic [7:0]    remain_ff, remain_in;

   // Clearing pass.
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   // Pipeline: memory read stage, then output register.
   logic          s1_valid_ff, s1_valid_in;
   rsp_ctl_type   s1_ctl_ff, s1_ctl_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff;
   logic          rsp_rvalid_ff;
   logic          rsp_last_ff;
   logic [2:0]    rsp_status_ff;
   logic [1:0]    rsp_phase_ff;

   logic          accept;
   logic          s1_adv;
   logic          func;
   logic [7:0]    bus_byte;
   logic          store_we;
   logic          load_re;
   logic [AC-1:0] room;
   logic [7:0]    ram_q;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;

   assign func     = req_tuser;
   assign bus_byte = req_tdata;

   // Handshake: a new request enters whenever no clearing pass runs and the read stage is free or moving on.
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_active_ff && (!s1_valid_ff || !rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign room = MEM_BOUND - addr_ff;

   // Decode one request against the current transfer state.
   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      cmd_in     = cmd_ff;
      addr_hi_in = addr_hi_ff;
      addr_in    = addr_ff;
      remain_in  = remain_ff;
      store_we   = 1'b0;
      load_re    = 1'b0;
      s1_ctl_in  = '{is_load: 1'b0, last: 1'b0, status: ST_OK, phase: phase_ff};

      if (!link_ready_ff) begin
         s1_ctl_in.status = ST_NOTREADY;
      end else if (phase_ff == PH_LOAD) begin
         if (!func) begin
            s1_ctl_in.status = ST_UNEXPECTED;
         end else begin
            load_re           = 1'b1;
            s1_ctl_in.is_load = 1'b1;
            s1_ctl_in.last    = (remain_ff <= 8'd1);
            addr_in           = addr_ff + AC'(1);
            if (remain_ff != 8'd0) begin
               remain_in = remain_ff - 8'd1;
            end
            if (remain_ff <= 8'd1) begin
               phase_in = PH_HEADER;
            end
         end
      end else if (func) begin
         s1_ctl_in.status = ST_UNEXPECTED;
      end else if (phase_ff == PH_STORE) begin
         // Bytes past the end of memory are taken but dropped.
         if (addr_ff < MEM_BOUND) begin
            store_we = 1'b1;
            addr_in  = addr_ff + AC'(1);
         end
         if (remain_ff != 8'd0) begin
            remain_in = remain_ff - 8'd1;
         end
         if (remain_ff <= 8'd1) begin
            phase_in = PH_HEADER;
         end
      end else begin
         unique case (hdr_idx_ff)
            HDR_CMD: begin
               cmd_in     = bus_byte;
               hdr_idx_in = HDR_ADDR_HI;
            end
            HDR_ADDR_HI: begin
               addr_hi_in = bus_byte;
               hdr_idx_in = HDR_ADDR_LO;
            end
            HDR_ADDR_LO: begin
               addr_in    = AC'(addr_mod({addr_hi_ff, bus_byte}));
               hdr_idx_in = HDR_LEN;
            end
            default: begin
               // Length byte: check the header and open or reject the transfer.
               hdr_idx_in = HDR_CMD;
               remain_in  = 8'd0;
               phase_in   = PH_HEADER;
               if (cmd_ff == CMD_STORE) begin
                  if (bus_byte > max_wr_ff) begin
                     s1_ctl_in.status = ST_WLEN;
                  end else if (bus_byte != 8'd0) begin
                     remain_in = bus_byte;
                     phase_in  = PH_STORE;
                  end
               end else if (cmd_ff == CMD_LOAD) begin
                  if (bus_byte > max_rd_ff) begin
                     s1_ctl_in.status = ST_RLEN;
                  end else if (bus_byte != 8'd0) begin
                     // Clip the transfer at the end of memory.
                     remain_in = ({{(AC-8){1'b0}}, bus_byte} < room) ? bus_byte : room[7:0];
                     phase_in  = PH_LOAD;
                  end
               end else begin
                  s1_ctl_in.status = ST_BADCMD;
               end
            end
         endcase
      end
      s1_ctl_in.phase = phase_in;
   end

   // RAM port sharing: the clearing pass owns the write port until it ends.
   always_comb begin
      if (clr_active_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = 8'd0;
      end else begin
         ram_we    = accept && store_we;
         ram_waddr = addr_ff[AW-1:0];
         ram_wdata = bus_byte;
      end
   end

   // A STORE and a later LOAD are always separated by a full header,
   // so a read never meets a write to the same byte in flight.
   btm_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept && load_re),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (ram_q)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ready_ff <= 1'b0;
         max_wr_ff     <= 8'd0;
         max_rd_ff     <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CFG_LINK_READY:    link_ready_ff <= csr_wdata[0];
            CFG_MAX_WRITE_LEN: max_wr_ff     <= csr_wdata;
            CFG_MAX_READ_LEN:  max_rd_ff     <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // Transfer state updates on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_idx_ff <= HDR_CMD;
         cmd_ff     <= 8'd0;
         addr_hi_ff <= 8'd0;
         addr_ff    <= '0;
         remain_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         cmd_ff     <= cmd_in;
         addr_hi_ff <= addr_hi_in;
         addr_ff    <= addr_in;
         remain_ff  <= remain_in;
      end
   end

   // Clearing pass after reset, one byte per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == MEM_LAST) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // Read stage and output register control.
   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; RAM data joins the response as it leaves the read stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff <= s1_ctl_in;
      end
      if (s1_adv) begin
         rsp_data_ff   <= s1_ctl_ff.is_load ? ram_q : 8'd0;
         rsp_rvalid_ff <= s1_ctl_ff.is_load;
         rsp_last_ff   <= s1_ctl_ff.last;
         rsp_status_ff <= s1_ctl_ff.status;
         rsp_phase_ff  <= s1_ctl_ff.phase;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_phase_ff, rsp_status_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_rvalid_ff;
   assign rsp_tlast  = rsp_last_ff;

   // No request may enter while the memory is being cleared.
   assert property (@(posedge clock) disable iff (reset) clr_active_ff |-> !req_tready)
      else $error("request accepted during clearing pass");

   // An open transfer always has payload bytes left.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HEADER) |-> (remain_ff != 8'd0))
      else $error("open transfer with zero remaining count");

   // A LOAD never addresses past the end of memory.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LOAD) |-> (addr_ff < MEM_BOUND))
      else $error("load address beyond memory");

   // The final LOAD byte always closes the transfer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_phase_ff == PH_HEADER))
      else $error("last load byte did not return to header phase");

endmodule

// ----- hw/rtl/btm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module btm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/tb_bus_target_memory_command_engine.sv -----
// Self-checking testbench for the bus target memory command engine.
`timescale 1ns / 1ps

module tb_bus_target_memory_command_engine;
   import btm_pkg::*;

   localparam int MEM_BYTES = MEM_BYTES_DEFAULT;

   // What the target should answer to one bus access.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
      logic [2:0] status;
      logic [1:0] phase;
   } target_reply_type;

   // One bus access together with the answer it is due.
   typedef struct {
      logic             is_read;
      logic [7:0]       value;
      target_reply_type reply;
   } bus_access_type;

   // Receiver behaviors that alternate during the run.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_ALTERNATE,
      READY_MOSTLY,
      READY_SELDOM
   } ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] bus_byte
   logic        req_tuser = 1'b0;     // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] read_data, [10:8] status, [12:11] phase
   logic        rsp_tuser;            // [0] read_valid
   logic        rsp_tlast;            // read_last
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = 2'd0;
   logic [7:0]  csr_wdata = 8'h00;

   // Target state as the bus sees it, advanced as accesses are generated.
   logic        cfg_link = 1'b0;
   logic [7:0]  cfg_wlen = 8'h00;
   logic [7:0]  cfg_rlen = 8'h00;
   logic [1:0]  tgt_phase = PH_HEADER;
   logic [1:0]  tgt_index = HDR_CMD;
   logic [7:0]  tgt_cmd = 8'h00;
   int          tgt_addr = 0;
   int          tgt_left = 0;
   logic [7:0]  shadow_mem [MEM_BYTES];
   int          useful_count = 0;

   bus_access_type   access_queue [$];
   target_reply_type reply_queue [$];
   bus_access_type   in_flight;

   logic           req_taken = 1'b0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             holds_asked = 0;
   int             holds_served = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   int          fault_count = 0;
   int          reply_count = 0;
   int          load_bytes = 0;
   int          refused_headers = 0;
   int          settings_applied = 0;

   bus_target_memory_command_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Advances the target by one bus access and returns its answer.
   function automatic target_reply_type advance_target(input logic is_read,
                                                       input logic [7:0] value);
      target_reply_type r;
      int room;
      r = '0;
      r.status = ST_OK;
      if (!cfg_link) begin
         r.status = ST_NOTREADY;
      end else if (tgt_phase == PH_LOAD) begin
         if (!is_read) begin
            r.status = ST_UNEXPECTED;
         end else begin
            r.data  = shadow_mem[tgt_addr % MEM_BYTES];
            r.valid = 1'b1;
            r.last  = (tgt_left <= 1);
            tgt_addr++;
            if (tgt_left > 0) tgt_left--;
            if (tgt_left == 0) tgt_phase = PH_HEADER;
         end
      end else if (is_read) begin
         r.status = ST_UNEXPECTED;
      end else if (tgt_phase == PH_STORE) begin
         // Bytes past the end of memory are taken but dropped.
         if (tgt_addr < MEM_BYTES) begin
            shadow_mem[tgt_addr] = value;
            tgt_addr++;
         end
         if (tgt_left > 0) tgt_left--;
         if (tgt_left == 0) tgt_phase = PH_HEADER;
      end else begin
         case (tgt_index)
            HDR_CMD: begin
               tgt_cmd = value;
               tgt_index = HDR_ADDR_HI;
            end
            HDR_ADDR_HI: begin
               tgt_addr = int'(value);
               tgt_index = HDR_ADDR_LO;
            end
            HDR_ADDR_LO: begin
               tgt_addr = ((tgt_addr << 8) | int'(value)) % MEM_BYTES;
               tgt_index = HDR_LEN;
            end
            default: begin
               // Length byte: open the transfer or refuse the header.
               tgt_index = HDR_CMD;
               tgt_phase = PH_HEADER;
               tgt_left = 0;
               if (tgt_cmd == CMD_STORE) begin
                  if (value > cfg_wlen) begin
                     r.status = ST_WLEN;
                  end else if (value != 8'd0) begin
                     tgt_left = int'(value);
                     tgt_phase = PH_STORE;
                  end
               end else if (tgt_cmd == CMD_LOAD) begin
                  if (value > cfg_rlen) begin
                     r.status = ST_RLEN;
                  end else if (value != 8'd0) begin
                     room = MEM_BYTES - tgt_addr;
                     tgt_left = (int'(value) < room) ? int'(value) : room;
                     tgt_phase = PH_LOAD;
                  end
               end else begin
                  r.status = ST_BADCMD;
               end
            end
         endcase
      end
      r.phase = tgt_phase;
      return r;
   endfunction

   // Queues one bus access with the answer it is due.
   task automatic emit(input logic is_read, input logic [7:0] value);
      bus_access_type a;
      a.is_read = is_read;
      a.value   = value;
      a.reply   = advance_target(is_read, value);
      if (a.reply.status != ST_NOTREADY && a.reply.status != ST_UNEXPECTED) useful_count++;
      access_queue.push_back(a);
   endtask

   task automatic emit_header(input logic [7:0] cmd, input logic [7:0] hi,
                              input logic [7:0] lo, input logic [7:0] len);
      emit(1'b0, cmd);
      emit(1'b0, hi);
      emit(1'b0, lo);
      emit(1'b0, len);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Writes all three registers; the link bit goes out with random upper bits.
   task automatic set_limits(input logic link, input logic [7:0] wlen,
                             input logic [7:0] rlen);
      logic [7:0] link_word;
      link_word = 8'($urandom_range(0, 255));
      link_word[0] = link;
      write_reg(CFG_LINK_READY, link_word);
      write_reg(CFG_MAX_WRITE_LEN, wlen);
      write_reg(CFG_MAX_READ_LEN, rlen);
      cfg_link = link;
      cfg_wlen = wlen;
      cfg_rlen = rlen;
      settings_applied++;
   endtask

   // Waits until every request went out and every response came back.
   task automatic wait_drained;
      do @(posedge clock);
      while (access_queue.size() != 0 || req_tvalid || reply_queue.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed transfers with random content, some noise in between.
   task automatic fill_random(input int count);
      int start;
      int roll;
      int limit;
      logic [7:0] cmd;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] len;
      start = useful_count;
      while (useful_count - start < count) begin
         if (tgt_phase == PH_LOAD) begin
            emit($urandom_range(0, 19) != 0, 8'($urandom_range(0, 255)));
         end else if (tgt_phase == PH_STORE) begin
            emit($urandom_range(0, 19) == 0, 8'($urandom_range(0, 255)));
         end else if (tgt_index != HDR_CMD || $urandom_range(0, 4) == 0) begin
            roll = $urandom_range(0, 3);
            cmd = 8'($urandom_range(0, 255));
            if (roll == 1) cmd = $urandom_range(0, 1) ? CMD_LOAD : CMD_STORE;
            emit(roll == 0, cmd);
         end else begin
            roll = $urandom_range(0, 9);
            cmd = (roll < 5) ? CMD_STORE : (roll < 9) ? CMD_LOAD : 8'($urandom_range(0, 255));
            // Addresses favor a small window that aliases, and the end of memory.
            roll = $urandom_range(0, 9);
            hi = 8'($urandom_range(0, 255));
            lo = 8'($urandom_range(0, 255));
            if (roll < 5) begin
               hi[5:0] = 6'h00;
               lo = 8'($urandom_range(0, 63));
            end else if (roll < 7) begin
               hi[5:0] = 6'h3F;
               lo = 8'($urandom_range(192, 255));
            end
            limit = (cmd == CMD_LOAD) ? int'(cfg_rlen) : int'(cfg_wlen);
            roll = $urandom_range(0, 9);
            if (roll < 7)
               len = (limit == 0) ? 8'd0 : 8'($urandom_range(1, (limit < 12) ? limit : 12));
            else if (roll == 7) len = 8'(limit);
            else if (roll == 8) len = 8'd0;
            else len = (limit == 255) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(limit + 1, 255));
            emit_header(cmd, hi, lo, len);
         end
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (access_queue.size() > 0) begin
            in_flight = access_queue.pop_front();
            req_tdata  <= in_flight.value;
            req_tuser  <= in_flight.is_read;
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver: a changing ready pattern, plus long hold-offs on demand.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_served != holds_asked) begin
            holds_served++;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 150);
            end else begin
               mode_left--;
            end
            case (ready_mode)
               READY_ALWAYS:    rsp_tready <= 1'b1;
               READY_ALTERNATE: rsp_tready <= ~rsp_tready;
               READY_MOSTLY:    rsp_tready <= ($urandom_range(0, 9) < 7);
               default:         rsp_tready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   // Monitor: records accepted requests and checks each response in order.
   always @(posedge clock) begin
      target_reply_type want;
      target_reply_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) reply_queue.push_back(in_flight.reply);
         if (rsp_tvalid && rsp_tready) begin
            got.data   = rsp_tdata[7:0];
            got.status = rsp_tdata[10:8];
            got.phase  = rsp_tdata[12:11];
            got.valid  = rsp_tuser;
            got.last   = rsp_tlast;
            reply_count++;
            if (got.valid) load_bytes++;
            if (got.status == ST_WLEN || got.status == ST_RLEN || got.status == ST_BADCMD)
               refused_headers++;
            if (reply_queue.size() == 0) begin
               log_fault($sformatf("response %0d arrived with none outstanding", reply_count));
            end else begin
               want = reply_queue.pop_front();
               if (got !== want)
                  log_fault($sformatf({"response %0d: expected data %h valid %b last %b ",
                     "status %0d phase %0d, got data %h valid %b last %b status %0d phase %0d"},
                     reply_count, want.data, want.valid, want.last, want.status, want.phase,
                     got.data, got.valid, got.last, got.status, got.phase));
            end
         end
      end
   end

   // Run limit.
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // Stimulus sequence.
   initial begin
      logic       plan_link [7];
      logic [7:0] plan_wlen [7];
      logic [7:0] plan_rlen [7];
      int         plan_count [7];
      plan_link  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      plan_wlen  = '{8'd255, 8'd16, 8'd0, 8'd1, 8'd255, 8'd0, 8'd255};
      plan_rlen  = '{8'd255, 8'd8, 8'd0, 8'd1, 8'd255, 8'd0, 8'd4};
      plan_count = '{260, 220, 120, 120, 0, 260, 250};
      plan_wlen[5] = 8'($urandom_range(2, 254));
      plan_rlen[5] = 8'($urandom_range(2, 254));
      for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = 8'h00;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Link still down after reset: every access is refused.
      emit(1'b0, 8'hFF);
      emit(1'b1, 8'h00);
      wait_drained();

      set_limits(1'b1, 8'd255, 8'd255);
      // A read with no transfer open.
      emit(1'b1, 8'h00);
      // Raw address FFFF masks to the last byte; the second payload byte is dropped.
      emit_header(CMD_STORE, 8'hFF, 8'hFF, 8'd2);
      emit(1'b0, 8'hA5);
      emit(1'b0, 8'h5A);
      // A full-length load from the last byte is cut to one, after a stray write.
      emit_header(CMD_LOAD, 8'h3F, 8'hFF, 8'hFF);
      emit(1'b0, 8'h00);
      emit(1'b1, 8'hFF);
      // Unknown command.
      emit_header(8'h00, 8'h00, 8'h00, 8'h01);
      wait_drained();

      // Zero limits: any nonzero length is refused, a zero length is an empty transfer.
      set_limits(1'b1, 8'd0, 8'd0);
      emit_header(CMD_STORE, 8'h00, 8'h00, 8'd1);
      emit_header(CMD_LOAD, 8'h00, 8'h00, 8'd0);
      wait_drained();

      for (int p = 0; p < 7; p++) begin
         set_limits(plan_link[p], plan_wlen[p], plan_rlen[p]);
         if (plan_link[p]) begin
            fill_random(plan_count[p]);
         end else begin
            for (int k = 0; k < 20; k++)
               emit(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
         // Stall the receiver long enough for the target to back up its input.
         if (p == 0 || p == 5) holds_asked++;
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("Run covered %0d responses under %0d register settings: %0d load bytes returned,",
               reply_count, settings_applied, load_bytes);
      $display("%0d headers refused for length or command.", refused_headers);
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d responses did not match.", fault_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
